// ----- rtl/hvn_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the height map vertex normal block.
package hvn_pkg;

    // Width of a vector that enters the normalizer (sum of six Q1.14 normals)
    localparam int VEC_W = 18;

    // Fixed y component of every face before normalization
    localparam logic signed [VEC_W-1:0] FACE_Y = -18'sd10;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;

    typedef struct packed {
        logic [7:0] height_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        vertex_row;
        logic [9:0]         vertex_column;
        logic               last_in_run;
        logic               end_of_frame;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic       accept;
        logic       shift;
        logic       clr_acc;
        logic       add_acc;
        logic       norm_start;
        logic       norm_src_acc;
        logic       load_out;
        logic [2:0] vtx;
        logic [2:0] face;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [3:0] emit;
        logic [5:0] face_ok;
        logic       out_free;
    } status_t;

endpackage

// ----- rtl/hvn_if.sv -----
`timescale 1ns / 1ps
// Valid/ready stream interfaces for height samples and vertex normals.
interface hvn_in_if;
    logic               valid;
    logic               ready;
    hvn_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hvn_out_if;
    logic               valid;
    logic               ready;
    hvn_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/heightmap_vertex_normals.sv -----
`timescale 1ns / 1ps
// Height map smoothed vertex normals: top level.
//
// Height bytes enter on the samples stream in raster order, one request per
// valid/ready handshake. Unit vertex normals (Q1.14) leave on the normals
// stream with their row and column, last_in_run on the final normal a
// sample causes and end_of_frame on the map's last vertex. Row 0 samples
// give none; other samples give up to four.
// The cfg port (cfg_we, cfg_index, cfg_data) sets column_count and
// row_count; a write restarts the frame at row 0, column 0.
// A sample is captured on acceptance and then shifted into the window. Each
// normal then needs one normalizer pass per adjacent face plus one more for
// the sum; a skipped face needs no pass. The shared iterative normalizer (15
// result bits, one per cycle) sets the pace of this work.
// A sample is taken only once the previous one has been fully processed.
// One output register holds a finished normal; when the receiver stalls,
// the block still finishes the next normal and then waits to hand it over.
// Reset restores 1024 x 1024, clears position and the output valid; the
// line store needs no clearing.
module heightmap_vertex_normals #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    hvn_in_if.sink      samples,
    hvn_out_if.source   normals,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hvn_pkg::cmd_t                      cmd;
    hvn_pkg::status_t                   status;
    logic                               norm_done;
    logic signed [hvn_pkg::VEC_W-1:0]   nv_x, nv_y, nv_z;
    logic signed [15:0]                 nr_x, nr_y, nr_z;

    hvn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .status    (status),
        .norm_done (norm_done),
        .cmd       (cmd)
    );

    hvn_dp #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (samples.data),
        .cmd       (cmd),
        .status    (status),
        .nv_x      (nv_x),
        .nv_y      (nv_y),
        .nv_z      (nv_z),
        .nr_x      (nr_x),
        .nr_y      (nr_y),
        .nr_z      (nr_z),
        .out_valid (normals.valid),
        .out_ready (normals.ready),
        .out_data  (normals.data)
    );

    hvn_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.norm_start),
        .vec_x (nv_x),
        .vec_y (nv_y),
        .vec_z (nv_z),
        .done  (norm_done),
        .res_x (nr_x),
        .res_y (nr_y),
        .res_z (nr_z)
    );

endmodule

// ----- rtl/hvn_norm.sv -----
`timescale 1ns / 1ps
// Iterative normalizer: scales a 3-vector to unit length in Q1.14.
module hvn_norm (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [hvn_pkg::VEC_W-1:0]  vec_x,
    input  logic signed [hvn_pkg::VEC_W-1:0]  vec_y,
    input  logic signed [hvn_pkg::VEC_W-1:0]  vec_z,
    output logic                              done,
    output logic signed [15:0]                res_x,
    output logic signed [15:0]                res_y,
    output logic signed [15:0]                res_z
);

    localparam int MAG_W = hvn_pkg::VEC_W - 1;
    localparam int SQ_W  = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 2;
    localparam int ACC_W = 70;
    localparam int QB    = 15;

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_SQ   = 2'd1;
    localparam logic [1:0] P_INIT = 2'd2;
    localparam logic [1:0] P_ITER = 2'd3;

    logic [1:0]               phase_reg, phase_next;
    logic [3:0]               cnt_reg, cnt_next;
    logic                     done_reg, done_next;

    logic                     neg_reg [3];
    logic [MAG_W-1:0]         mag_reg [3];
    logic [SQ_W-1:0]          sq_reg  [3];
    logic [SUM_W-1:0]         s_reg;
    logic signed [ACC_W-1:0]  t_reg   [3];
    logic signed [ACC_W-1:0]  u_reg   [3];
    logic [QB-1:0]            q_reg   [3];

    logic signed [hvn_pkg::VEC_W-1:0] vin [3];
    logic [MAG_W-1:0]         sel_mag;
    logic [SQ_W-1:0]          prod;
    logic [4:0]               sh_u, sh_u1;
    logic [5:0]               sh_s;
    logic signed [ACC_W-1:0]  s_ext;
    logic signed [ACC_W-1:0]  trial [3];
    logic signed [ACC_W-1:0]  bound [3];
    logic                     fits  [3];
    logic signed [15:0]       res   [3];

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    // Shared squarer and one trial step per lane:
    // (2q-1)^2 * s <= m^2 * 2^30, kept incrementally with t = (2q-1)^2 s, u = (2q-1) s
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd1:    sel_mag = mag_reg[1];
            2'd2:    sel_mag = mag_reg[2];
            default: sel_mag = mag_reg[0];
        endcase
        prod  = sel_mag * sel_mag;
        sh_u  = {1'b0, cnt_reg} + 5'd2;
        sh_u1 = {1'b0, cnt_reg} + 5'd1;
        sh_s  = {1'b0, cnt_reg, 1'b0} + 6'd2;
        s_ext = $signed(ACC_W'(s_reg));
        for (int k = 0; k < 3; k++)
        begin
            trial[k] = t_reg[k] + (u_reg[k] <<< sh_u) + (s_ext <<< sh_s);
            bound[k] = $signed(ACC_W'(sq_reg[k]) << 30);
            fits[k]  = trial[k] <= bound[k];
        end
    end

    // Sequencer: three squares, set-up, fifteen result bits
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (phase_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    phase_next = P_SQ;
                    cnt_next   = 4'd0;
                end
            end
            P_SQ:
            begin
                if (cnt_reg == 4'd2)
                    phase_next = P_INIT;
                else
                    cnt_next = cnt_reg + 4'd1;
            end
            P_INIT:
            begin
                phase_next = P_ITER;
                cnt_next   = 4'(QB - 1);
            end
            P_ITER:
            begin
                if (cnt_reg == 4'd0)
                begin
                    phase_next = P_IDLE;
                    done_next  = 1'b1;
                end
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            cnt_reg   <= 4'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start && phase_reg == P_IDLE)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg_reg[k] <= vin[k][hvn_pkg::VEC_W-1];
                mag_reg[k] <= vin[k][hvn_pkg::VEC_W-1] ? MAG_W'(-vin[k]) : MAG_W'(vin[k]);
            end
            s_reg <= '0;
        end
        case (phase_reg)
            P_SQ:
            begin
                case (cnt_reg[1:0])
                    2'd1:    sq_reg[1] <= prod;
                    2'd2:    sq_reg[2] <= prod;
                    default: sq_reg[0] <= prod;
                endcase
                s_reg <= s_reg + SUM_W'(prod);
            end
            P_INIT:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    t_reg[k] <= s_ext;
                    u_reg[k] <= -s_ext;
                    q_reg[k] <= '0;
                end
            end
            P_ITER:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (fits[k])
                    begin
                        t_reg[k] <= trial[k];
                        u_reg[k] <= u_reg[k] + (s_ext <<< sh_u1);
                        q_reg[k] <= q_reg[k] | (QB'(1) << cnt_reg);
                    end
                end
            end
            default: ;
        endcase
    end

    // Restore signs; a zero vector gives zero
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (s_reg == '0)
                res[k] = 16'sd0;
            else if (neg_reg[k])
                res[k] = -$signed({1'b0, q_reg[k]});
            else
                res[k] = $signed({1'b0, q_reg[k]});
        end
    end

    assign done  = done_reg;
    assign res_x = res[0];
    assign res_y = res[1];
    assign res_z = res[2];

endmodule

// ----- rtl/hvn_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences input requests, vertices and faces through the normalizer.
module hvn_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  hvn_pkg::status_t status,
    input  logic             norm_done,
    output hvn_pkg::cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_VSEL  = 3'd2;
    localparam logic [2:0] S_FACE  = 3'd3;
    localparam logic [2:0] S_FWAIT = 3'd4;
    localparam logic [2:0] S_VWAIT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    localparam logic [2:0] LAST_VTX  = 3'd4;
    localparam logic [2:0] LAST_FACE = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [2:0] vtx_reg, vtx_next;
    logic [2:0] face_reg, face_next;

    always_comb
    begin
        state_next = state_reg;
        vtx_next   = vtx_reg;
        face_next  = face_reg;
        cmd        = '0;
        cmd.vtx    = vtx_reg;
        cmd.face   = face_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_SHIFT;
                end
            end
            // window shift and line store write-back
            S_SHIFT:
            begin
                cmd.shift  = 1'b1;
                vtx_next   = 3'd0;
                state_next = S_VSEL;
            end
            // next vertex completed by this request
            S_VSEL:
            begin
                if (vtx_reg == LAST_VTX)
                    state_next = S_IDLE;
                else if (status.emit[vtx_reg[1:0]])
                begin
                    cmd.clr_acc = 1'b1;
                    face_next   = 3'd0;
                    state_next  = S_FACE;
                end
                else
                    vtx_next = vtx_reg + 3'd1;
            end
            // walk the six adjacent faces, then renormalize the sum
            S_FACE:
            begin
                if (face_reg == LAST_FACE)
                begin
                    cmd.norm_start   = 1'b1;
                    cmd.norm_src_acc = 1'b1;
                    state_next       = S_VWAIT;
                end
                else if (status.face_ok[face_reg])
                begin
                    cmd.norm_start = 1'b1;
                    state_next     = S_FWAIT;
                end
                else
                    face_next = face_reg + 3'd1;
            end
            S_FWAIT:
            begin
                if (norm_done)
                begin
                    cmd.add_acc = 1'b1;
                    face_next   = face_reg + 3'd1;
                    state_next  = S_FACE;
                end
            end
            S_VWAIT:
            begin
                if (norm_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    vtx_next     = vtx_reg + 3'd1;
                    state_next   = S_VSEL;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vtx_reg   <= 3'd0;
            face_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            vtx_reg   <= vtx_next;
            face_reg  <= face_next;
        end
    end

endmodule

// ----- rtl/hvn_dp.sv -----
`timescale 1ns / 1ps
// Datapath: sizes, raster position, line store, 3x3 window, accumulator, output register.
module hvn_dp #(
    parameter int MAX_COLUMNS = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [15:0]                       cfg_data,
    input  hvn_pkg::in_item_t                 in_data,
    input  hvn_pkg::cmd_t                     cmd,
    output hvn_pkg::status_t                  status,
    output logic signed [hvn_pkg::VEC_W-1:0]  nv_x,
    output logic signed [hvn_pkg::VEC_W-1:0]  nv_y,
    output logic signed [hvn_pkg::VEC_W-1:0]  nv_z,
    input  logic signed [15:0]                nr_x,
    input  logic signed [15:0]                nr_y,
    input  logic signed [15:0]                nr_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output hvn_pkg::out_item_t                out_data
);

    localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int VW    = hvn_pkg::VEC_W;

    logic [10:0]            column_count_reg;
    logic [15:0]            row_count_reg;
    logic [COL_W-1:0]       pos_c_reg, pos_c_next;
    logic [15:0]            pos_r_reg, pos_r_next;
    logic [COL_W-1:0]       in_c_reg;
    logic [15:0]            in_r_reg;
    logic [7:0]             sample_reg;
    logic [15:0]            rd_reg;
    logic [15:0]            line_mem [MAX_COLUMNS];
    logic [7:0]             win_reg [9];
    logic signed [VW-1:0]   acc_x_reg, acc_y_reg, acc_z_reg;
    logic                   out_valid_reg, out_valid_next;
    hvn_pkg::out_item_t     out_reg;

    logic [15:0]            cols_ext, cols_eff;
    logic [COL_W-1:0]       c_last;
    logic [15:0]            r_last;
    logic                   cfg_hit;

    logic [15:0]            vi;
    logic [COL_W-1:0]       vj;
    logic [31:0]            vj_ext;
    logic                   top, bottom, left, right;
    logic                   is_last;

    logic [1:0]             vr, vc, qr, qc;
    logic                   use_b;
    logic [7:0]             wpad [4][4];
    logic [7:0]             p00, p01, p10, p11;
    logic signed [8:0]      fx, fz;

    // Effective map size, clamped to the supported range
    always_comb
    begin
        cols_ext = {5'd0, column_count_reg};
        if (cols_ext < 16'd2)
            cols_eff = 16'd2;
        else if (cols_ext > 16'(MAX_COLUMNS))
            cols_eff = 16'(MAX_COLUMNS);
        else
            cols_eff = cols_ext;
        c_last = COL_W'(cols_eff - 16'd1);
        r_last = (row_count_reg < 16'd2) ? 16'd1 : row_count_reg - 16'd1;
    end

    assign cfg_hit = cfg_we &&
                     (cfg_index == hvn_pkg::CFG_COLUMN_COUNT ||
                      cfg_index == hvn_pkg::CFG_ROW_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= 11'd1024;
            row_count_reg    <= 16'd1024;
        end
        else if (cfg_we)
        begin
            if (cfg_index == hvn_pkg::CFG_COLUMN_COUNT)
                column_count_reg <= cfg_data[10:0];
            else if (cfg_index == hvn_pkg::CFG_ROW_COUNT)
                row_count_reg <= cfg_data;
        end
    end

    // Raster position of the next sample; any register write restarts the frame
    always_comb
    begin
        pos_c_next = pos_c_reg;
        pos_r_next = pos_r_reg;
        if (cfg_hit)
        begin
            pos_c_next = '0;
            pos_r_next = '0;
        end
        else if (cmd.accept)
        begin
            if (pos_c_reg == c_last)
            begin
                pos_c_next = '0;
                pos_r_next = (pos_r_reg == r_last) ? 16'd0 : pos_r_reg + 16'd1;
            end
            else
                pos_c_next = pos_c_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_c_reg <= '0;
            pos_r_reg <= '0;
        end
        else
        begin
            pos_c_reg <= pos_c_next;
            pos_r_reg <= pos_r_next;
        end
    end

    // Request capture, line store read on accept and write-back on shift
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= in_data.height_sample;
            in_c_reg   <= pos_c_reg;
            in_r_reg   <= pos_r_reg;
            rd_reg     <= line_mem[pos_c_reg];
        end
        if (cmd.shift)
            line_mem[in_c_reg] <= {rd_reg[7:0], sample_reg};
    end

    // 3x3 window moves one column left
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[3*k]   <= win_reg[3*k+1];
                win_reg[3*k+1] <= win_reg[3*k+2];
            end
            win_reg[2] <= rd_reg[15:8];
            win_reg[5] <= rd_reg[7:0];
            win_reg[8] <= sample_reg;
        end
    end

    // Vertices completed by the current request and faces around the selected one
    always_comb
    begin
        vi     = cmd.vtx[1] ? in_r_reg : in_r_reg - 16'd1;
        vj     = cmd.vtx[0] ? in_c_reg : in_c_reg - COL_W'(1);
        vj_ext = 32'(vj);
        top    = vi != 16'd0;
        bottom = vi != r_last;
        left   = vj != '0;
        right  = vj != c_last;

        status.emit[0] = (in_r_reg != 16'd0) && (in_c_reg != '0);
        status.emit[1] = (in_r_reg != 16'd0) && (in_c_reg == c_last);
        status.emit[2] = (in_r_reg != 16'd0) && (in_r_reg == r_last) && (in_c_reg != '0);
        status.emit[3] = (in_r_reg != 16'd0) && (in_r_reg == r_last) && (in_c_reg == c_last);

        // up-left A, B; up-right A; down-right A, B; down-left B
        status.face_ok = {bottom && left, bottom && right, bottom && right,
                          top && right, top && left, top && left};
        status.out_free = !out_valid_reg || out_ready;

        case (cmd.vtx[1:0])
            2'd0:    is_last = status.emit[3:1] == 3'd0;
            2'd1:    is_last = status.emit[3:2] == 2'd0;
            2'd2:    is_last = !status.emit[3];
            default: is_last = 1'b1;
        endcase
    end

    // Face vector of the selected quad
    always_comb
    begin
        vr = cmd.vtx[1] ? 2'd2 : 2'd1;
        vc = cmd.vtx[0] ? 2'd2 : 2'd1;
        case (cmd.face)
            3'd0:
            begin
                qr = vr - 2'd1; qc = vc - 2'd1; use_b = 1'b0;
            end
            3'd1:
            begin
                qr = vr - 2'd1; qc = vc - 2'd1; use_b = 1'b1;
            end
            3'd2:
            begin
                qr = vr - 2'd1; qc = vc;        use_b = 1'b0;
            end
            3'd3:
            begin
                qr = vr;        qc = vc;        use_b = 1'b0;
            end
            3'd4:
            begin
                qr = vr;        qc = vc;        use_b = 1'b1;
            end
            default:
            begin
                qr = vr;        qc = vc - 2'd1; use_b = 1'b1;
            end
        endcase

        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                wpad[r][c] = (r < 3 && c < 3) ? win_reg[r*3+c] : 8'd0;

        p00 = wpad[qr][qc];
        p01 = wpad[qr][qc + 2'd1];
        p10 = wpad[qr + 2'd1][qc];
        p11 = wpad[qr + 2'd1][qc + 2'd1];

        if (use_b)
        begin
            fx = $signed({1'b0, p11}) - $signed({1'b0, p01});
            fz = $signed({1'b0, p01}) - $signed({1'b0, p00});
        end
        else
        begin
            fx = $signed({1'b0, p10}) - $signed({1'b0, p00});
            fz = $signed({1'b0, p11}) - $signed({1'b0, p10});
        end

        nv_x = cmd.norm_src_acc ? acc_x_reg : {{(VW-9){fx[8]}}, fx};
        nv_y = cmd.norm_src_acc ? acc_y_reg : hvn_pkg::FACE_Y;
        nv_z = cmd.norm_src_acc ? acc_z_reg : {{(VW-9){fz[8]}}, fz};
    end

    // Sum of face normals
    always_ff @(posedge clk)
    begin
        if (cmd.clr_acc)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_z_reg <= '0;
        end
        else if (cmd.add_acc)
        begin
            acc_x_reg <= acc_x_reg + {{(VW-16){nr_x[15]}}, nr_x};
            acc_y_reg <= acc_y_reg + {{(VW-16){nr_y[15]}}, nr_y};
            acc_z_reg <= acc_z_reg + {{(VW-16){nr_z[15]}}, nr_z};
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg.normal_x      <= nr_x;
            out_reg.normal_y      <= nr_y;
            out_reg.normal_z      <= nr_z;
            out_reg.vertex_row    <= vi;
            out_reg.vertex_column <= vj_ext[9:0];
            out_reg.last_in_run   <= is_last;
            out_reg.end_of_frame  <= !bottom && !right;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- tb/tb_heightmap_vertex_normals.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the height map vertex normal block.
module tb_heightmap_vertex_normals;

    localparam int MAX_COLS   = 1024;
    localparam int DRAIN_WAIT = 800;
    localparam int STALL_CAP  = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = hvn_pkg::CFG_COLUMN_COUNT;
    logic [15:0] cfg_data = '0;

    hvn_in_if  in_ch ();
    hvn_out_if out_ch ();

    heightmap_vertex_normals #(.MAX_COLUMNS(MAX_COLS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (in_ch),
        .normals  (out_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    // Shadow of the block: line buffer, 3x3 window, raster position, sizes
    logic [7:0]  shadow_lines [0:2*MAX_COLS-1];
    logic [7:0]  shadow_win [0:8];
    int unsigned raster_row, raster_col;
    int unsigned map_cols = 1024, map_rows = 1024;

    hvn_pkg::out_item_t normals_due [$];
    int        fail_count = 0;
    int        normals_seen = 0;
    int        heights_sent = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_cycles = 0;
    int        quiet_cycles = 0;

    // Unit-length scale of one component: round(16384*v/sqrt(s)), ties away
    function automatic longint q14_component(longint v, longint unsigned s);
        longint unsigned mag;
        logic [127:0]    rhs, lhs;
        int unsigned     lo, hi, q;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        rhs = 128'(mag * mag) << 30;
        lo = 0;
        hi = 16384;
        while (lo < hi)
        begin
            q = (lo + hi + 1) / 2;
            lhs = 128'(2 * q - 1) * 128'(2 * q - 1) * 128'(s);
            if (lhs <= rhs)
                lo = q;
            else
                hi = q - 1;
        end
        return (v < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    task automatic unit_vector(input longint vx, vy, vz, output longint nx, ny, nz);
        longint unsigned s;
        s = longint'(vx * vx) + longint'(vy * vy) + longint'(vz * vz);
        nx = (s == 0) ? 0 : q14_component(vx, s);
        ny = (s == 0) ? 0 : q14_component(vy, s);
        nz = (s == 0) ? 0 : q14_component(vz, s);
    endtask

    function automatic longint win_px(int unsigned r, int unsigned c);
        if (r > 2 || c > 2)
            return 0;
        return longint'(shadow_win[r * 3 + c]);
    endfunction

    // Add the unit normal of face A or B of the quad at window (r,c)
    task automatic add_face(input int unsigned r, c, input bit face_b,
                            inout longint ax, ay, az);
        longint p00, p01, p10, p11, nx, ny, nz;
        p00 = win_px(r, c);
        p01 = win_px(r, c + 1);
        p10 = win_px(r + 1, c);
        p11 = win_px(r + 1, c + 1);
        if (face_b)
            unit_vector(p11 - p01, -10, p01 - p00, nx, ny, nz);
        else
            unit_vector(p10 - p00, -10, p11 - p10, nx, ny, nz);
        ax += nx;
        ay += ny;
        az += nz;
    endtask

    task automatic queue_normal(input int unsigned i, j, vr, vc);
        bit                 top, bottom, left, right;
        longint             ax, ay, az, nx, ny, nz;
        hvn_pkg::out_item_t item;
        top = (i != 0);
        bottom = (i != map_rows - 1);
        left = (j != 0);
        right = (j != map_cols - 1);
        ax = 0;
        ay = 0;
        az = 0;
        if (top && left)
        begin
            add_face(vr - 1, vc - 1, 1'b0, ax, ay, az);
            add_face(vr - 1, vc - 1, 1'b1, ax, ay, az);
        end
        if (top && right)
            add_face(vr - 1, vc, 1'b0, ax, ay, az);
        if (bottom && right)
        begin
            add_face(vr, vc, 1'b0, ax, ay, az);
            add_face(vr, vc, 1'b1, ax, ay, az);
        end
        if (bottom && left)
            add_face(vr, vc - 1, 1'b1, ax, ay, az);
        unit_vector(ax, ay, az, nx, ny, nz);
        item.normal_x = nx[15:0];
        item.normal_y = ny[15:0];
        item.normal_z = nz[15:0];
        item.vertex_row = i[15:0];
        item.vertex_column = j[9:0];
        item.last_in_run = 1'b0;
        item.end_of_frame = !bottom && !right;
        normals_due = {normals_due, item};
    endtask

    // Advance the shadow by one accepted height and queue the normals it completes
    task automatic absorb_height(input logic [7:0] h);
        int unsigned r, c, n;
        logic [7:0]  up2, up1;
        r = raster_row;
        c = raster_col;
        n = 0;
        if (c >= map_cols || r >= map_rows)
        begin
            r = 0;
            c = 0;
        end
        up2 = shadow_lines[2 * c];
        up1 = shadow_lines[2 * c + 1];
        for (int k = 0; k < 3; k++)
        begin
            shadow_win[k * 3] = shadow_win[k * 3 + 1];
            shadow_win[k * 3 + 1] = shadow_win[k * 3 + 2];
        end
        shadow_win[2] = up2;
        shadow_win[5] = up1;
        shadow_win[8] = h;
        shadow_lines[2 * c] = up1;
        shadow_lines[2 * c + 1] = h;
        if (r >= 1)
        begin
            if (c >= 1)
            begin
                queue_normal(r - 1, c - 1, 1, 1);
                n++;
            end
            if (c == map_cols - 1)
            begin
                queue_normal(r - 1, c, 1, 2);
                n++;
            end
            if (r == map_rows - 1)
            begin
                if (c >= 1)
                begin
                    queue_normal(r, c - 1, 2, 1);
                    n++;
                end
                if (c == map_cols - 1)
                begin
                    queue_normal(r, c, 2, 2);
                    n++;
                end
            end
        end
        if (n > 0)
            normals_due[normals_due.size() - 1].last_in_run = 1'b1;
        c++;
        if (c >= map_cols)
        begin
            c = 0;
            r++;
            if (r >= map_rows)
                r = 0;
        end
        raster_row = r;
        raster_col = c;
    endtask

    // Register write; only called while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        int unsigned v;
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == hvn_pkg::CFG_COLUMN_COUNT)
        begin
            v = {21'd0, value[10:0]};
            map_cols = (v < 2) ? 2 : ((v > MAX_COLS) ? MAX_COLS : v);
        end
        else
        begin
            v = {16'd0, value};
            map_rows = (v < 2) ? 2 : v;
        end
        raster_row = 0;
        raster_col = 0;
    endtask

    // Offer one height request; returns at the edge where it is accepted
    task automatic send_height(input logic [7:0] h);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid = 1'b0;
        end
        @(negedge clk);
        in_ch.valid = 1'b1;
        in_ch.data.height_sample = h;
        do
            @(posedge clk);
        while (!in_ch.ready);
        absorb_height(h);
        heights_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (normals_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic set_size(input int unsigned cols, rows);
        write_reg(hvn_pkg::CFG_COLUMN_COUNT, cols[15:0]);
        write_reg(hvn_pkg::CFG_ROW_COUNT, rows[15:0]);
    endtask

    // Receiver: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // Compare every delivered normal with the oldest one predicted
    always @(posedge clk)
    begin
        hvn_pkg::out_item_t e, g;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            g = out_ch.data;
            normals_seen++;
            if (normals_due.size() == 0)
            begin
                $error("normal at row %0d col %0d with none expected",
                       g.vertex_row, g.vertex_column);
                fail_count++;
            end
            else
            begin
                e = normals_due.pop_front();
                check_field("normal_x", e.normal_x, g.normal_x);
                check_field("normal_y", e.normal_y, g.normal_y);
                check_field("normal_z", e.normal_z, g.normal_z);
                check_field("vertex_row", e.vertex_row, g.vertex_row);
                check_field("vertex_column", e.vertex_column, g.vertex_column);
                check_field("last_in_run", e.last_in_run, g.last_in_run);
                check_field("end_of_frame", e.end_of_frame, g.end_of_frame);
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_CAP)
        begin
            $display("FAIL heightmap_vertex_normals");
            $finish;
        end
    end

    // Smallest map, clamped sizes, extreme heights, then a 3x3 with frame wrap
    task automatic test_directed();
        logic [7:0] pat [0:12];
        pat = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'hFF, 8'h00, 8'h01, 8'h80,
                8'hFE, 8'h7F, 8'hFF, 8'h00, 8'hFF};
        send_idle_pct = 0;
        stall_pct = 0;
        set_size(0, 1);
        send_height(8'h00);
        send_height(8'hFF);
        send_height(8'hFF);
        send_height(8'h00);
        drain();
        set_size(3, 3);
        foreach (pat[k])
            send_height(pat[k]);
        drain();
    endtask

    // Random small frames under each idling mode; sizes change between phases
    task automatic test_random_maps();
        int modes_idle [4] = '{0, 49, 0, 18};
        int modes_stall [4] = '{0, 0, 49, 18};
        int unsigned cols, rows, n;
        for (int m = 0; m < 4; m++)
        begin
            send_idle_pct = modes_idle[m];
            stall_pct = modes_stall[m];
            for (int p = 0; p < 4; p++)
            begin
                cols = $urandom_range(8, 2);
                rows = $urandom_range(5, 2);
                if (p == 3)
                    cols = $urandom_range(1, 0);
                set_size(cols, rows);
                // whole frames mostly, sometimes cut short by the next write
                n = map_cols * map_rows * $urandom_range(2, 1);
                if ($urandom_range(3) == 0)
                    n = $urandom_range(n, 1);
                for (int k = 0; k < n && k < 40; k++)
                    send_height($urandom_range(255));
                drain();
            end
        end
    endtask

    // Receiver holds off long enough for the block to back up its input
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        set_size(6, 4);
        hold_cycles = 600;
        for (int k = 0; k < 24; k++)
            send_height($urandom_range(255));
        drain();
    endtask

    // Start of a clamped wide row and the tallest row count
    task automatic test_extreme_sizes();
        send_idle_pct = 0;
        stall_pct = 10;
        set_size(2047, 2);
        for (int k = 0; k < 40; k++)
            send_height($urandom_range(255));
        drain();
        set_size(5, 65535);
        for (int k = 0; k < 20; k++)
            send_height($urandom_range(255));
        drain();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        raster_row = 0;
        raster_col = 0;
        foreach (shadow_win[k])
            shadow_win[k] = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random_maps();
        test_backpressure();
        test_extreme_sizes();
        $display("Covered %0d height requests and %0d normals over clamped, small,",
                 heights_sent, normals_seen);
        $display("wide and 65535-row maps, with random idling and a long stall.");
        if (fail_count == 0 && normals_due.size() == 0)
            $display("PASS heightmap_vertex_normals");
        else
            $display("FAIL heightmap_vertex_normals");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/hvn_pkg.sv
rtl/hvn_if.sv
rtl/hvn_norm.sv
rtl/hvn_ctrl.sv
rtl/hvn_dp.sv
rtl/heightmap_vertex_normals.sv
tb/tb_heightmap_vertex_normals.sv
